FILE: hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, types and decision functions of the quadrant route select.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAG_BITS   = COORD_BITS + 1;     // |coord| incl. -min
    localparam int SUM_BITS   = COORD_BITS + 2;     // |x| + |y|
    localparam int CMD_BITS   = 3;
    localparam int PORT_BITS  = 5;

    localparam int IN_FIELD_BITS  = CMD_BITS + 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((PORT_BITS + 7) / 8) * 8;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // protocol codes
    localparam logic [CMD_BITS-1:0] CMD_BROADCAST   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INDIVIDUALS = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_RADIUS      = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_AREA        = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_UNICAST     = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_OFS_UNICAST = 3'd5;

    // register word index
    localparam logic [APB_ADDR_BITS-3:0] REG_UNICAST_MODE = '0;

    // port bits
    localparam logic [PORT_BITS-1:0] PORT_NONE = 5'b00000;
    localparam logic [PORT_BITS-1:0] PORT_L    = 5'b00001;
    localparam logic [PORT_BITS-1:0] PORT_N    = 5'b00010;
    localparam logic [PORT_BITS-1:0] PORT_E    = 5'b00100;
    localparam logic [PORT_BITS-1:0] PORT_S    = 5'b01000;
    localparam logic [PORT_BITS-1:0] PORT_W    = 5'b10000;
    localparam logic [PORT_BITS-1:0] PORT_NBRS = 5'b11110;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [MAG_BITS-1:0]   t_mag;
    typedef logic        [PORT_BITS-1:0]  t_ports;

    // decoded item leaving the front end, entering the remainder pipe
    typedef struct packed {
        logic                  valid;
        t_ports                mask;      // everything except pitched local bit
        logic                  want_loc;  // pitched local bit still to decide
        t_mag                  num_x;
        t_mag                  num_y;
        logic [COORD_BITS-1:0] pitch_x;
        logic [COORD_BITS-1:0] pitch_y;
        logic [COORD_BITS-1:0] half_x;
        logic [COORD_BITS-1:0] half_y;
    } t_front;

    function automatic t_mag f_mag(input t_coord v);
        logic signed [MAG_BITS-1:0] e;
        e = MAG_BITS'(v);
        return (v < 0) ? t_mag'(-e) : t_mag'(e);
    endfunction

    // |v| < h with h signed; h <= 0 never holds
    function automatic logic f_below(input t_mag m, input t_coord h);
        return (h > 0) && (m < t_mag'(h));
    endfunction

    function automatic t_ports f_spread(input t_coord x, input t_coord y);
        t_ports d;
        d = PORT_NONE;
        if (x >= 0 && y > 0) begin
            d = PORT_E | ((x == 0) ? PORT_N : PORT_NONE);
        end else if (x < 0 && y >= 0) begin
            d = PORT_N | ((y == 0) ? PORT_W : PORT_NONE);
        end else if (x <= 0 && y < 0) begin
            d = PORT_W | ((x == 0) ? PORT_S : PORT_NONE);
        end else if (x > 0 && y <= 0) begin
            d = PORT_S | ((y == 0) ? PORT_E : PORT_NONE);
        end
        return d;
    endfunction

    function automatic t_ports f_area(input t_coord x, input t_coord y,
                                      input logic in_x, input logic in_y);
        t_ports d;
        d = PORT_L;
        if (in_x || in_y) begin
            if (x >= 0 && y > 0) begin
                if (in_x) d = d | PORT_E;
                if (x == 0 && in_y) d = d | PORT_N;
            end else if (x < 0 && y >= 0) begin
                if (in_y) d = d | PORT_N;
                if (y == 0 && in_x) d = d | PORT_W;
            end else if (x <= 0 && y < 0) begin
                if (in_x) d = d | PORT_W;
                if (x == 0 && in_y) d = d | PORT_S;
            end else if (x > 0 && y <= 0) begin
                if (in_y) d = d | PORT_S;
                if (y == 0 && in_x) d = d | PORT_E;
            end else begin
                d = PORT_NBRS;
            end
        end
        return d;
    endfunction

    function automatic t_ports f_clockwise(input t_coord x, input t_coord y);
        t_ports d;
        if (x >= 0 && y > 0)       d = (x == 0) ? PORT_N : PORT_E;
        else if (x < 0 && y >= 0)  d = (y == 0) ? PORT_W : PORT_N;
        else if (x <= 0 && y < 0)  d = (x == 0) ? PORT_S : PORT_W;
        else if (x > 0 && y <= 0)  d = (y == 0) ? PORT_E : PORT_S;
        else                       d = PORT_L;
        return d;
    endfunction

    function automatic t_ports f_yfirst(input t_coord x, input t_coord y);
        t_ports d;
        if (y > 0)      d = PORT_N;
        else if (y < 0) d = PORT_S;
        else if (x > 0) d = PORT_E;
        else if (x < 0) d = PORT_W;
        else            d = PORT_L;
        return d;
    endfunction

    function automatic t_ports f_offset(input t_coord x, input t_coord y,
                                        input t_coord sx, input t_coord sy);
        t_ports d;
        if (x >= 0 && y > 0)       d = (x == 0 || sy == 0) ? PORT_N : PORT_E;
        else if (x < 0 && y >= 0)  d = (y == 0 || sx == 0) ? PORT_W : PORT_N;
        else if (x <= 0 && y < 0)  d = (x == 0 || sy == 0) ? PORT_S : PORT_W;
        else if (x > 0 && y <= 0)  d = (y == 0 || sx == 0) ? PORT_E : PORT_S;
        else                       d = PORT_L;
        return d;
    endfunction

endpackage

FILE: hdl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Input register and decode stage: all of the mask except the pitched local bit.
// ----------------------------------------------------------------------------
module qrs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [qrs_pkg::CMD_BITS-1:0]         i_cmd,
    input  qrs_pkg::t_coord                      i_dest_x,
    input  qrs_pkg::t_coord                      i_dest_y,
    input  qrs_pkg::t_coord                      i_src_x,
    input  qrs_pkg::t_coord                      i_src_y,
    input  logic                                 i_unicast_mode,
    output qrs_pkg::t_front                      o_front
);

    logic                         r_v0;
    logic [qrs_pkg::CMD_BITS-1:0] r_cmd;
    qrs_pkg::t_coord              r_dx, r_dy, r_sx, r_sy;
    qrs_pkg::t_front              r_front, n_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0          <= 1'b0;
            r_front.valid <= 1'b0;
        end else if (i_en) begin
            r_v0          <= i_valid;
            r_front.valid <= n_front.valid;
        end
        if (i_en) begin
            r_cmd <= i_cmd;
            r_dx  <= i_dest_x;
            r_dy  <= i_dest_y;
            r_sx  <= i_src_x;
            r_sy  <= i_src_y;
            r_front.mask     <= n_front.mask;
            r_front.want_loc <= n_front.want_loc;
            r_front.num_x    <= n_front.num_x;
            r_front.num_y    <= n_front.num_y;
            r_front.pitch_x  <= n_front.pitch_x;
            r_front.pitch_y  <= n_front.pitch_y;
            r_front.half_x   <= n_front.half_x;
            r_front.half_y   <= n_front.half_y;
        end
    end

    qrs_pkg::t_mag                     mag_x, mag_y;
    logic [qrs_pkg::SUM_BITS-1:0]      hop_sum, radius;
    logic                              at_src, in_rad, pitch_ok;
    logic [qrs_pkg::COORD_BITS:0]      px_inc, py_inc;

    always_comb begin
        mag_x    = qrs_pkg::f_mag(r_sx);
        mag_y    = qrs_pkg::f_mag(r_sy);
        hop_sum  = qrs_pkg::SUM_BITS'(mag_x) + qrs_pkg::SUM_BITS'(mag_y);
        radius   = (r_cmd == qrs_pkg::CMD_RADIUS)
                 ? qrs_pkg::SUM_BITS'(unsigned'(r_dx)) : '0;
        at_src   = (r_sx == 0) && (r_sy == 0);
        in_rad   = (radius == 0) || (hop_sum < radius);
        pitch_ok = (r_dx > 0) && (r_dy > 0);
        px_inc   = (qrs_pkg::COORD_BITS+1)'(unsigned'(r_dx)) + 1'b1;
        py_inc   = (qrs_pkg::COORD_BITS+1)'(unsigned'(r_dy)) + 1'b1;

        n_front.valid    = r_v0;
        n_front.want_loc = 1'b0;
        n_front.num_x    = mag_x;
        n_front.num_y    = mag_y;
        n_front.pitch_x  = r_dx;
        n_front.pitch_y  = r_dy;
        n_front.half_x   = px_inc[qrs_pkg::COORD_BITS:1];
        n_front.half_y   = py_inc[qrs_pkg::COORD_BITS:1];

        unique case (r_cmd)
            qrs_pkg::CMD_BROADCAST, qrs_pkg::CMD_RADIUS: begin
                if (!in_rad)     n_front.mask = qrs_pkg::PORT_L;
                else if (at_src) n_front.mask = qrs_pkg::PORT_NBRS;
                else n_front.mask = qrs_pkg::PORT_L | qrs_pkg::f_spread(r_sx, r_sy);
            end
            qrs_pkg::CMD_INDIVIDUALS: begin
                // local bit is settled after the remainder pipe
                n_front.mask     = at_src ? qrs_pkg::PORT_NBRS
                                          : qrs_pkg::f_spread(r_sx, r_sy);
                n_front.want_loc = pitch_ok && !at_src;
            end
            qrs_pkg::CMD_AREA: begin
                n_front.mask = qrs_pkg::f_area(r_sx, r_sy,
                                               qrs_pkg::f_below(mag_x, r_dx),
                                               qrs_pkg::f_below(mag_y, r_dy));
            end
            qrs_pkg::CMD_UNICAST: begin
                n_front.mask = i_unicast_mode ? qrs_pkg::f_yfirst(r_dx, r_dy)
                                              : qrs_pkg::f_clockwise(r_dx, r_dy);
            end
            qrs_pkg::CMD_OFS_UNICAST: begin
                n_front.mask = qrs_pkg::f_offset(r_dx, r_dy, r_sx, r_sy);
            end
            default: begin
                n_front.mask = qrs_pkg::PORT_NONE;
            end
        endcase
    end

    assign o_front = r_front;

endmodule

FILE: hdl/qrs_rem_pipe.sv
// ----------------------------------------------------------------------------
// qrs_rem_pipe
// Restoring remainder, one dividend bit per stage on both axes, then the
// pitch-offset compare that sets the local bit.
// ----------------------------------------------------------------------------
module qrs_rem_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  qrs_pkg::t_front         i_front,
    output logic                    o_valid,
    output qrs_pkg::t_ports         o_mask
);

    localparam int NSTG = qrs_pkg::MAG_BITS;

    typedef struct packed {
        logic                           valid;
        qrs_pkg::t_ports                mask;
        logic                           want_loc;
        logic [qrs_pkg::COORD_BITS-1:0] rem_x;
        logic [qrs_pkg::COORD_BITS-1:0] rem_y;
        qrs_pkg::t_mag                  num_x;
        qrs_pkg::t_mag                  num_y;
        logic [qrs_pkg::COORD_BITS-1:0] pitch_x;
        logic [qrs_pkg::COORD_BITS-1:0] pitch_y;
        logic [qrs_pkg::COORD_BITS-1:0] half_x;
        logic [qrs_pkg::COORD_BITS-1:0] half_y;
    } t_rem_stage;

    // shift in the next dividend bit, subtract the divisor if it fits
    function automatic logic [qrs_pkg::COORD_BITS-1:0] f_rem_step(
        input logic [qrs_pkg::COORD_BITS-1:0] rem,
        input logic                           bit_in,
        input logic [qrs_pkg::COORD_BITS-1:0] div
    );
        logic [qrs_pkg::COORD_BITS:0] t;
        logic [qrs_pkg::COORD_BITS:0] d;
        t = {rem, bit_in};
        d = {1'b0, div};
        if (t >= d) t = t - d;
        return t[qrs_pkg::COORD_BITS-1:0];
    endfunction

    t_rem_stage r_stg [NSTG];
    t_rem_stage n_stg [NSTG];
    t_rem_stage seed;

    always_comb begin
        seed.valid    = i_front.valid;
        seed.mask     = i_front.mask;
        seed.want_loc = i_front.want_loc;
        seed.rem_x    = '0;
        seed.rem_y    = '0;
        seed.num_x    = i_front.num_x;
        seed.num_y    = i_front.num_y;
        seed.pitch_x  = i_front.pitch_x;
        seed.pitch_y  = i_front.pitch_y;
        seed.half_x   = i_front.half_x;
        seed.half_y   = i_front.half_y;
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        t_rem_stage prev;
        if (k == 0) begin : g_first
            assign prev = seed;
        end else begin : g_next
            assign prev = r_stg[k-1];
        end

        always_comb begin
            n_stg[k]       = prev;
            n_stg[k].rem_x = f_rem_step(prev.rem_x, prev.num_x[qrs_pkg::MAG_BITS-1],
                                        prev.pitch_x);
            n_stg[k].rem_y = f_rem_step(prev.rem_y, prev.num_y[qrs_pkg::MAG_BITS-1],
                                        prev.pitch_y);
            n_stg[k].num_x = {prev.num_x[qrs_pkg::MAG_BITS-2:0], 1'b0};
            n_stg[k].num_y = {prev.num_y[qrs_pkg::MAG_BITS-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k].valid <= 1'b0;
            end else if (i_en) begin
                r_stg[k].valid <= n_stg[k].valid;
            end
            if (i_en) begin
                r_stg[k].mask     <= n_stg[k].mask;
                r_stg[k].want_loc <= n_stg[k].want_loc;
                r_stg[k].rem_x    <= n_stg[k].rem_x;
                r_stg[k].rem_y    <= n_stg[k].rem_y;
                r_stg[k].num_x    <= n_stg[k].num_x;
                r_stg[k].num_y    <= n_stg[k].num_y;
                r_stg[k].pitch_x  <= n_stg[k].pitch_x;
                r_stg[k].pitch_y  <= n_stg[k].pitch_y;
                r_stg[k].half_x   <= n_stg[k].half_x;
                r_stg[k].half_y   <= n_stg[k].half_y;
            end
        end
    end

    logic            r_valid;
    qrs_pkg::t_ports r_mask, n_mask;
    t_rem_stage      last;

    always_comb begin
        last   = r_stg[NSTG-1];
        n_mask = last.mask;
        if (last.want_loc && last.rem_x == last.half_x && last.rem_y == last.half_y) begin
            n_mask = last.mask | qrs_pkg::PORT_L;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= last.valid;
        end
        if (i_en) begin
            r_mask <= n_mask;
        end
    end

    assign o_valid = r_valid;
    assign o_mask  = r_mask;

endmodule

FILE: hdl/noc_quadrant_route_select_top.sv
// ----------------------------------------------------------------------------
// noc_quadrant_route_select_top
// Output-port selector for a 2D mesh router: one header in, one port mask out.
// ----------------------------------------------------------------------------
// Pipeline: input and decode registers, the 17-stage remainder pipe (one
//   magnitude bit per stage), then compare and output registers ahead of
//   m_axis_tvalid.
// Throughput: one item per cycle; the pipe stalls only when the output
//   register and its skid stage both hold results.
// Reset: i_rst_n synchronous, active low; clears all valid bits and sets
//   unicast_mode to clockwise (0). No clearing pass.
module noc_quadrant_route_select_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cmd[2:0], dest_x[18:3], dest_y[34:19], src_x[50:35], src_y[66:51], zero pad
    input  logic [qrs_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
    // result item
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // port_mask[4:0], zero pad
    output logic [qrs_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qrs_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [qrs_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [qrs_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);

    localparam int CB = qrs_pkg::COORD_BITS;
    localparam int CM = qrs_pkg::CMD_BITS;

    // ---- configuration register ---------------------------------------------
    logic r_unicast_mode;
    logic reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready
                 && (paddr[qrs_pkg::APB_ADDR_BITS-1:2] == qrs_pkg::REG_UNICAST_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unicast_mode <= 1'b0;
        end else if (reg_wr) begin
            r_unicast_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[qrs_pkg::APB_ADDR_BITS-1:2] == qrs_pkg::REG_UNICAST_MODE) begin
            prdata[0] = r_unicast_mode;
        end
    end

    // ---- pipeline --------------------------------------------------------------
    // Whole pipe advances while the skid stage is empty.
    logic            r_skid_valid;
    logic            pipe_en;
    qrs_pkg::t_front front;
    logic            pipe_valid;
    qrs_pkg::t_ports pipe_mask;

    assign pipe_en       = !r_skid_valid;
    assign s_axis_tready = pipe_en;

    qrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (pipe_en),
        .i_valid        (s_axis_tvalid),
        .i_cmd          (s_axis_tdata[CM-1:0]),
        .i_dest_x       (s_axis_tdata[CM+CB-1:CM]),
        .i_dest_y       (s_axis_tdata[CM+2*CB-1:CM+CB]),
        .i_src_x        (s_axis_tdata[CM+3*CB-1:CM+2*CB]),
        .i_src_y        (s_axis_tdata[CM+4*CB-1:CM+3*CB]),
        .i_unicast_mode (r_unicast_mode),
        .o_front        (front)
    );

    qrs_rem_pipe u_rem_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_front (front),
        .o_valid (pipe_valid),
        .o_mask  (pipe_mask)
    );

    // ---- output register with skid stage ---------------------------------------
    // A result that finds the output register held goes to the skid stage,
    // which then freezes the pipe until the output drains.
    logic            r_out_valid;
    qrs_pkg::t_ports r_out_mask;
    qrs_pkg::t_ports r_skid_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (m_axis_tready || !r_out_valid) begin
            r_out_valid <= pipe_valid;
        end else if (pipe_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_mask <= r_skid_mask;
            end
        end else if (m_axis_tready || !r_out_valid) begin
            r_out_mask <= pipe_mask;
        end else begin
            r_skid_mask <= pipe_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = qrs_pkg::OUT_DATA_BITS'(r_out_mask);

endmodule

FILE: hdl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the route selector, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tready,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [qrs_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qrs_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [qrs_pkg::APB_DATA_BITS-1:0]      pwdata,
    input  logic [qrs_pkg::APB_DATA_BITS-1:0]      prdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input back-pressure only when a result is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // pad bits above the mask stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[qrs_pkg::OUT_DATA_BITS-1:qrs_pkg::PORT_BITS] == '0)
        else $error("nonzero pad in result");

    // register write is read back
    a_reg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == '0 ##1 paddr == '0
        |-> prdata[0] == $past(pwdata[0]) && prdata[qrs_pkg::APB_DATA_BITS-1:1] == '0)
        else $error("unicast_mode readback mismatch");

endmodule

bind noc_quadrant_route_select_top qrs_checker u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
